// File: rtl/core/ile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine: the command and
// result payloads, command, status and cell operation codes, and the
// controller states.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int ILE_CAPACITY     = 16;
    localparam int ILE_ELEMENT_BITS = 32;

    // Fixed field widths of the transfer payloads
    localparam int ILE_CMD_W   = 3;
    localparam int ILE_INDEX_W = 5;
    localparam int ILE_DATA_W  = 32;
    localparam int ILE_COUNT_W = 5;
    localparam int ILE_STAT_W  = 2;

    typedef enum logic [ILE_CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_SET    = 3'd4,
        CMD_FIND   = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_ile_cmd;

    typedef enum logic [ILE_STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_ABSENT = 2'd3
    } t_ile_status;

    // What every cell of the row does in the execute state
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SET
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_ile_state;

    typedef struct packed {
        logic [ILE_CMD_W-1:0]   command;
        logic [ILE_INDEX_W-1:0] index;
        logic [ILE_DATA_W-1:0]  value;
    } t_ile_in;

    typedef struct packed {
        logic [ILE_DATA_W-1:0]  read_value;
        logic [ILE_INDEX_W-1:0] position;
        logic [ILE_STAT_W-1:0]  status;
        logic [ILE_COUNT_W-1:0] entry_count;
    } t_ile_out;

endpackage

// File: rtl/core/indexed_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list held in a row of cells, one element per cell.
// ----------------------------------------------------------------------------
// The command is registered at the transfer edge, the cell row then shifts,
// writes or compares all slots at once in the execute state, and the response
// state priority-encodes the registered match flags and loads the result
// register once the output register is free. A new command is taken once the
// controller is back in idle, even while the previous result is still stalled
// in the output register; until then the input is stalled. Element storage has
// no reset; only live slots below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
    parameter int CAPACITY     = ile_pkg::ILE_CAPACITY,
    parameter int ELEMENT_BITS = ile_pkg::ILE_ELEMENT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ile_pkg::t_ile_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ile_pkg::t_ile_out o_out_data
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > ile_pkg::ILE_INDEX_W) ? CW : ile_pkg::ILE_INDEX_W;
    localparam int AW    = $clog2(CAPACITY);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    ile_pkg::t_ile_state r_state;
    ile_pkg::t_ile_state n_state;

    logic [ile_pkg::ILE_CMD_W-1:0] r_cmd;
    logic [CMP_W-1:0]              r_idx;
    logic [ELEMENT_BITS-1:0]       r_val;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    ile_pkg::t_ile_status          r_status;
    ile_pkg::t_ile_status          n_status;
    logic [ELEMENT_BITS-1:0]       r_rd;
    logic [ELEMENT_BITS-1:0]       n_rd;
    logic [CAPACITY-1:0]           r_match;
    logic                          r_out_valid;
    ile_pkg::t_ile_out             r_out;
    ile_pkg::t_ile_out             n_out;

    logic                          w_take_in;
    logic                          w_exec;
    logic                          w_load_out;
    logic [CMP_W-1:0]              w_cnt_ext;
    logic                          w_full;
    ile_pkg::t_cell_op             w_op_raw;
    ile_pkg::t_cell_op             w_cell_op;
    logic [ELEMENT_BITS-1:0]       w_entry [CAPACITY];
    logic [ELEMENT_BITS-1:0]       w_left  [CAPACITY];
    logic [ELEMENT_BITS-1:0]       w_right [CAPACITY];
    logic [CAPACITY-1:0]           w_match;
    logic                          w_hit;
    logic [CW-1:0]                 w_first;

    // ---------------- cell row ----------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_mid_r
            assign w_right[g] = w_entry[g+1];
        end

        ile_cell #(
            .ELEMENT_BITS (ELEMENT_BITS),
            .CMP_W        (CMP_W),
            .CELL_ID      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_pos   (r_idx),
            .i_cnt   (w_cnt_ext),
            .i_value (r_val),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // ---------------- controller ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ile_pkg::S_IDLE: if (i_in_valid) n_state = ile_pkg::S_EXEC;
            ile_pkg::S_EXEC: n_state = ile_pkg::S_RESP;
            ile_pkg::S_RESP: if (w_load_out) n_state = ile_pkg::S_IDLE;
            default:         n_state = ile_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ile_pkg::S_IDLE);
        w_take_in  = (r_state == ile_pkg::S_IDLE) && i_in_valid;
        w_exec     = (r_state == ile_pkg::S_EXEC);
        w_load_out = (r_state == ile_pkg::S_RESP) && (!r_out_valid || !i_out_stall);
    end

    // ---------------- execute decode ----------------
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_full    = (r_count == FULL_COUNT);
    assign w_cell_op = w_exec ? w_op_raw : ile_pkg::CELL_HOLD;

    always_comb begin
        w_op_raw = ile_pkg::CELL_HOLD;
        n_count  = r_count;
        n_status = ile_pkg::STAT_OK;
        n_rd     = '0;
        unique case (ile_pkg::t_ile_cmd'(r_cmd))
            ile_pkg::CMD_APPEND: begin
                if (w_full) begin
                    n_status = ile_pkg::STAT_FULL;
                end else begin
                    w_op_raw = ile_pkg::CELL_APPEND;
                    n_count  = r_count + 1'b1;
                end
            end
            ile_pkg::CMD_INSERT: begin
                // range is checked before fullness
                if (r_idx > w_cnt_ext) begin
                    n_status = ile_pkg::STAT_RANGE;
                end else if (w_full) begin
                    n_status = ile_pkg::STAT_FULL;
                end else begin
                    w_op_raw = ile_pkg::CELL_INSERT;
                    n_count  = r_count + 1'b1;
                end
            end
            ile_pkg::CMD_REMOVE: begin
                if (r_idx >= w_cnt_ext) begin
                    n_status = ile_pkg::STAT_RANGE;
                end else begin
                    w_op_raw = ile_pkg::CELL_REMOVE;
                    n_count  = r_count - 1'b1;
                end
            end
            ile_pkg::CMD_GET: begin
                if (r_idx >= w_cnt_ext) begin
                    n_status = ile_pkg::STAT_RANGE;
                end else begin
                    n_rd = w_entry[r_idx[AW-1:0]];
                end
            end
            ile_pkg::CMD_SET: begin
                if (r_idx >= w_cnt_ext) begin
                    n_status = ile_pkg::STAT_RANGE;
                end else begin
                    w_op_raw = ile_pkg::CELL_SET;
                end
            end
            ile_pkg::CMD_FIND: begin
                n_status = ile_pkg::STAT_OK;
            end
            ile_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_status = ile_pkg::STAT_OK;
            end
        endcase
    end

    // ---------------- result encode ----------------
    assign w_hit = |r_match;

    always_comb begin
        w_first = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_match[i]) w_first = CW'(i);
        end
    end

    always_comb begin
        n_out             = '0;
        n_out.read_value  = ile_pkg::ILE_DATA_W'(r_rd);
        n_out.entry_count = ile_pkg::ILE_COUNT_W'(r_count);
        if (r_cmd == ile_pkg::CMD_FIND) begin
            n_out.status   = w_hit ? ile_pkg::STAT_OK : ile_pkg::STAT_ABSENT;
            n_out.position = ile_pkg::ILE_INDEX_W'(w_hit ? w_first : r_count);
        end else begin
            n_out.status   = r_status;
            n_out.position = '0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ile_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_cmd <= i_in_data.command;
            r_idx <= CMP_W'(i_in_data.index);
            r_val <= ELEMENT_BITS'(i_in_data.value);
        end
        if (w_exec) begin
            r_status <= n_status;
            r_rd     <= n_rd;
            r_match  <= w_match;
        end
        if (w_load_out) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("list count above capacity");

    a_cells_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cell_op != ile_pkg::CELL_HOLD) |-> (r_state == ile_pkg::S_EXEC))
        else $error("cell row modified outside execute");

    a_count_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ($past(r_state) == ile_pkg::S_EXEC))
        else $error("count changed outside execute");

    a_result_after_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == ile_pkg::S_RESP))
        else $error("result appeared without a response cycle");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_in |=> (r_state == ile_pkg::S_EXEC))
        else $error("accepted command did not enter execute");

endmodule

// File: rtl/core/ile_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_cell
// One list slot. Holds a single element, takes its neighbor's element on an
// insert or remove shift, loads new data on append, insert or set, and flags a
// match against the broadcast key.
// ----------------------------------------------------------------------------
module ile_cell #(
    parameter int ELEMENT_BITS = ile_pkg::ILE_ELEMENT_BITS,
    parameter int CMP_W        = ile_pkg::ILE_INDEX_W,
    parameter int CELL_ID      = 0
) (
    input  logic                    i_clk,
    input  ile_pkg::t_cell_op       i_op,
    input  logic [CMP_W-1:0]        i_pos,
    input  logic [CMP_W-1:0]        i_cnt,
    input  logic [ELEMENT_BITS-1:0] i_value,
    input  logic [ELEMENT_BITS-1:0] i_left,
    input  logic [ELEMENT_BITS-1:0] i_right,
    output logic [ELEMENT_BITS-1:0] o_entry,
    output logic                    o_match
);

    localparam logic [CMP_W-1:0] MY_POS      = CMP_W'(CELL_ID);
    localparam logic [CMP_W-1:0] MY_POS_NEXT = CMP_W'(CELL_ID + 1);

    logic [ELEMENT_BITS-1:0] r_entry;
    logic [ELEMENT_BITS-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_op)
            ile_pkg::CELL_HOLD: begin
                n_entry = r_entry;
            end
            ile_pkg::CELL_APPEND: begin
                if (MY_POS == i_cnt) n_entry = i_value;
            end
            ile_pkg::CELL_INSERT: begin
                if (MY_POS == i_pos) begin
                    n_entry = i_value;
                end else if ((MY_POS > i_pos) && (MY_POS <= i_cnt)) begin
                    n_entry = i_left;
                end
            end
            ile_pkg::CELL_REMOVE: begin
                if ((MY_POS >= i_pos) && (MY_POS_NEXT < i_cnt)) n_entry = i_right;
            end
            ile_pkg::CELL_SET: begin
                if (MY_POS == i_pos) n_entry = i_value;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // only live slots may match
    assign o_match = (r_entry == i_value) && (MY_POS < i_cnt);

endmodule
